// ----- hw/rtl/tqed_pkg.sv -----
package tqed_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES  = 3;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W       = 5;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LEN_W-1:0]  length_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(QUEUE_DEPTH);

  // operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_DMAX = 2'd2;
  localparam logic [1:0] OP_DMIN = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  cap;
    logic  cap_first;
    addr_t cap_idx;
    logic  want_max;
    logic  head_only;
    logic  wr_enq;
    logic  wr_shift;
    addr_t wr_addr;
    logic  load_out;
    logic  zero_out;
  } cmd_t;

endpackage

// ----- hw/rtl/tqed_datapath.sv -----
module tqed_datapath (
  input  logic                                clk,
  input  tqed_pkg::cmd_t                      cmd,
  input  logic signed [tqed_pkg::DATA_W-1:0]  in_value_a,
  input  logic signed [tqed_pkg::DATA_W-1:0]  in_value_b,
  input  logic signed [tqed_pkg::DATA_W-1:0]  in_value_c,
  output logic signed [tqed_pkg::DATA_W-1:0]  out_removed_a,
  output logic signed [tqed_pkg::DATA_W-1:0]  out_removed_b,
  output logic signed [tqed_pkg::DATA_W-1:0]  out_removed_c
);

  // one memory per queue, shared addressing, separate write enables
  logic signed [tqed_pkg::DATA_W-1:0] queue_mem [tqed_pkg::NUM_QUEUES][tqed_pkg::QUEUE_DEPTH];

  logic signed [tqed_pkg::DATA_W-1:0] enq_val    [tqed_pkg::NUM_QUEUES];
  logic signed [tqed_pkg::DATA_W-1:0] rd_q_r     [tqed_pkg::NUM_QUEUES];
  logic signed [tqed_pkg::DATA_W-1:0] best_val_r [tqed_pkg::NUM_QUEUES];
  logic signed [tqed_pkg::DATA_W-1:0] best_val_nxt [tqed_pkg::NUM_QUEUES];
  tqed_pkg::addr_t                    best_idx_r [tqed_pkg::NUM_QUEUES];
  tqed_pkg::addr_t                    best_idx_nxt [tqed_pkg::NUM_QUEUES];
  logic signed [tqed_pkg::DATA_W-1:0] removed_r  [tqed_pkg::NUM_QUEUES];
  logic signed [tqed_pkg::DATA_W-1:0] wr_data    [tqed_pkg::NUM_QUEUES];
  logic                               wr_en      [tqed_pkg::NUM_QUEUES];

  assign enq_val[0] = in_value_a;
  assign enq_val[1] = in_value_b;
  assign enq_val[2] = in_value_c;

  // scan compare and write selection per queue
  always_comb begin
    for (int q = 0; q < tqed_pkg::NUM_QUEUES; q++) begin
      best_val_nxt[q] = best_val_r[q];
      best_idx_nxt[q] = best_idx_r[q];
      if (cmd.cap) begin
        if (cmd.cap_first ||
            (!cmd.head_only && (cmd.want_max ? (rd_q_r[q] > best_val_r[q])
                                             : (rd_q_r[q] < best_val_r[q])))) begin
          best_val_nxt[q] = rd_q_r[q];
          best_idx_nxt[q] = cmd.cap_idx;
        end
      end
      wr_data[q] = cmd.wr_enq ? enq_val[q] : rd_q_r[q];
      // entries past the removed one move one place towards the head
      wr_en[q]   = cmd.wr_enq || (cmd.wr_shift && (cmd.wr_addr >= best_idx_r[q]));
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < tqed_pkg::NUM_QUEUES; q++) begin
      if (wr_en[q]) begin
        queue_mem[q][cmd.wr_addr] <= wr_data[q];
      end
      if (cmd.rd_en) begin
        rd_q_r[q] <= queue_mem[q][cmd.rd_addr];
      end
      best_val_r[q] <= best_val_nxt[q];
      best_idx_r[q] <= best_idx_nxt[q];
      if (cmd.load_out) begin
        removed_r[q] <= cmd.zero_out ? '0 : best_val_r[q];
      end
    end
  end

  assign out_removed_a = removed_r[0];
  assign out_removed_b = removed_r[1];
  assign out_removed_c = removed_r[2];

endmodule

// ----- hw/rtl/tqed_ctrl.sv -----
module tqed_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [1:0]                 in_op,
  output logic                       in_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output tqed_pkg::length_t          out_length,
  output tqed_pkg::cmd_t             cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  tqed_pkg::cnt_t    cnt_r, cnt_nxt;
  tqed_pkg::cnt_t    idx_r, idx_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  tqed_pkg::length_t out_length_r, out_length_nxt;
  tqed_pkg::cnt_t    idx_inc;
  tqed_pkg::cnt_t    idx_dec;

  assign idx_inc  = tqed_pkg::cnt_t'(idx_r + 1'b1);
  assign idx_dec  = tqed_pkg::cnt_t'(idx_r - 1'b1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;
    cmd            = '0;
    cmd.want_max   = (op_r == tqed_pkg::OP_DMAX);
    cmd.head_only  = (op_r == tqed_pkg::OP_DEQ);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          idx_nxt = '0;
          if (in_op == tqed_pkg::OP_ENQ) begin
            state_nxt = S_FIN;
            if (cnt_r >= tqed_pkg::DEPTH_CNT) begin
              status_nxt = tqed_pkg::ST_FULL;
            end else begin
              status_nxt  = tqed_pkg::ST_OK;
              cmd.wr_enq  = 1'b1;
              cmd.wr_addr = tqed_pkg::addr_t'(cnt_r);
              cnt_nxt     = tqed_pkg::cnt_t'(cnt_r + 1'b1);
            end
          end else if (cnt_r == '0) begin
            status_nxt = tqed_pkg::ST_EMPTY;
            state_nxt  = S_FIN;
          end else begin
            status_nxt = tqed_pkg::ST_OK;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en     = (idx_r < cnt_r);
        cmd.rd_addr   = tqed_pkg::addr_t'(idx_r);
        cmd.cap       = (idx_r != '0);
        cmd.cap_first = (idx_r == tqed_pkg::cnt_t'(1));
        cmd.cap_idx   = tqed_pkg::addr_t'(idx_dec);
        if (idx_r == cnt_r) begin
          idx_nxt   = '0;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_SHIFT: begin
        cmd.rd_en    = (idx_inc < cnt_r);
        cmd.rd_addr  = tqed_pkg::addr_t'(idx_inc);
        cmd.wr_shift = (idx_r != '0);
        cmd.wr_addr  = tqed_pkg::addr_t'(idx_dec);
        if (idx_r == tqed_pkg::cnt_t'(cnt_r - 1'b1)) begin
          cnt_nxt   = tqed_pkg::cnt_t'(cnt_r - 1'b1);
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out   = 1'b1;
          cmd.zero_out   = (status_r != tqed_pkg::ST_OK) || (op_r == tqed_pkg::OP_ENQ);
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_length_nxt = tqed_pkg::length_t'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tqed_pkg::DEPTH_CNT)
    else $error("entry count beyond queue depth");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == tqed_pkg::OP_ENQ && cnt_r == tqed_pkg::DEPTH_CNT)
    |=> cnt_r == $past(cnt_r))
    else $error("enqueue on full queue changed the count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken word");

  a_shift_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && idx_r == tqed_pkg::cnt_t'(cnt_r - 1'b1))
    |=> (cnt_r == tqed_pkg::cnt_t'($past(cnt_r) - 1'b1) && state_r == S_FIN))
    else $error("removal did not shorten the queues by one");
`endif

endmodule

// ----- hw/rtl/triple_queue_extreme_delete_unit.sv -----
// three lock-step fifo queues of signed 32-bit words (depth tqed_pkg::QUEUE_DEPTH, 16 as
// built), kept packed with the head at entry 0. an op 0 word appends in_value_a/b/c to the
// tails, op 1 drops the three heads, op 2 / op 3 drop the first largest / smallest entry of
// each queue on its own. one result word per input word: status (0 ok, 1 empty, 2 full),
// the removed values (zero on enqueue or error) and the new length. one word is handled at
// a time; enqueue and error cases skip the scan and compaction passes, while a removal
// makes a scan pass through the one-read-port queue memories and then a compaction pass
// that rewrites one entry a cycle. the result sits in an output register, so a new word
// is taken while the last result waits to be collected.
module triple_queue_extreme_delete_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic signed [tqed_pkg::DATA_W-1:0] in_value_a,
  input  logic signed [tqed_pkg::DATA_W-1:0] in_value_b,
  input  logic signed [tqed_pkg::DATA_W-1:0] in_value_c,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [tqed_pkg::DATA_W-1:0] out_removed_a,
  output logic signed [tqed_pkg::DATA_W-1:0] out_removed_b,
  output logic signed [tqed_pkg::DATA_W-1:0] out_removed_c,
  output logic [tqed_pkg::LEN_W-1:0]         out_length
);

  // command bundle from sequencer to the queue memories
  tqed_pkg::cmd_t cmd;

  // sequencer: entry count, scan and compaction passes, result handshake
  tqed_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_op      (in_op),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_length (out_length),
    .cmd        (cmd)
  );

  // queue memories, per-queue extreme trackers and removed-value registers
  tqed_datapath u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .in_value_a    (in_value_a),
    .in_value_b    (in_value_b),
    .in_value_c    (in_value_c),
    .out_removed_a (out_removed_a),
    .out_removed_b (out_removed_b),
    .out_removed_c (out_removed_c)
  );

endmodule

// ----- tb/sv/triple_queue_extreme_delete_unit_test.sv -----
module triple_queue_extreme_delete_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tqed_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  // one result word as the block reports it
  typedef struct packed {
    logic [1:0] status;
    word_t      removed_a;
    word_t      removed_b;
    word_t      removed_c;
    length_t    length;
  } result_t;

  // one line of the opening table; reps repeats the same word
  typedef struct {
    logic [1:0] op;
    word_t      a;
    word_t      b;
    word_t      c;
    int         reps;
    bit         typed;
    result_t    want;
  } opening_row_t;

  localparam word_t   VMAX        = 32'sh7fff_ffff;
  localparam word_t   VMIN        = 32'sh8000_0000;
  localparam result_t NO_RESULT   = '0;
  localparam int      CYCLE_LIMIT = 1_000_000;
  localparam int      SETTLE      = 40;  // outlasts a full-queue removal
  localparam int      SEGMENTS    = 8;
  localparam int      SEG_WORDS   = 170;

  // idling per phase: none, sender, receiver, both
  localparam int SEND_IDLE [4] = '{0, 82, 0, 31};
  localparam int RECV_STALL[4] = '{0, 0, 82, 31};
  // enqueue share per segment, swinging the fill level between empty and full
  localparam int ENQ_SHARE [SEGMENTS] = '{50, 60, 45, 55, 40, 65, 50, 35};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_op;
  word_t      in_value_a;
  word_t      in_value_b;
  word_t      in_value_c;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  word_t      out_removed_a;
  word_t      out_removed_b;
  word_t      out_removed_c;
  length_t    out_length;

  // hand-written expectation travelling alongside the payload
  bit         word_typed;
  result_t    word_typed_want;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count = 0;
  int mismatches  = 0;
  int checked     = 0;
  int seen_ok     = 0;
  int seen_empty  = 0;
  int seen_full   = 0;
  int deepest     = 0;

  // shadow copy of the three queues, head at index 0
  word_t   held_a[$];
  word_t   held_b[$];
  word_t   held_c[$];
  result_t awaited_results[$];

  // opening table: empty removals, single-entry extremes, fill to full, ties
  opening_row_t opening_rows [16] = '{
    '{OP_DMAX, 0,    0,    0,    1, 1'b1, '{ST_EMPTY, 0, 0, 0, 5'd0}},
    '{OP_DEQ,  1,    2,    3,    1, 1'b1, '{ST_EMPTY, 0, 0, 0, 5'd0}},
    '{OP_DMIN, -1,   -1,   -1,   1, 1'b1, '{ST_EMPTY, 0, 0, 0, 5'd0}},
    '{OP_ENQ,  VMAX, VMIN, 0,    1, 1'b1, '{ST_OK,    0, 0, 0, 5'd1}},
    '{OP_DMAX, 9,    9,    9,    1, 1'b1, '{ST_OK, VMAX, VMIN, 0, 5'd0}},
    '{OP_DMIN, 0,    0,    0,    1, 1'b1, '{ST_EMPTY, 0, 0, 0, 5'd0}},
    '{OP_ENQ,  VMIN, VMAX, -1,   1, 1'b1, '{ST_OK,    0, 0, 0, 5'd1}},
    '{OP_DEQ,  0,    0,    0,    1, 1'b1, '{ST_OK, VMIN, VMAX, -1, 5'd0}},
    '{OP_ENQ,  3,    3,    3,    6, 1'b0, NO_RESULT},
    '{OP_ENQ,  VMAX, VMIN, 3,    1, 1'b0, NO_RESULT},
    '{OP_ENQ,  VMAX, VMIN, -5,   1, 1'b0, NO_RESULT},
    '{OP_ENQ,  3,    3,    3,    5, 1'b0, NO_RESULT},
    '{OP_ENQ,  VMIN, VMAX, 0,    3, 1'b0, NO_RESULT},
    '{OP_ENQ,  1,    2,    3,    1, 1'b1, '{ST_FULL,  0, 0, 0, 5'd16}},
    '{OP_DMAX, 0,    0,    0,    1, 1'b0, NO_RESULT},
    '{OP_DMIN, 0,    0,    0,    1, 1'b0, NO_RESULT}
  };

  triple_queue_extreme_delete_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_value_a    (in_value_a),
    .in_value_b    (in_value_b),
    .in_value_c    (in_value_c),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_removed_a (out_removed_a),
    .out_removed_b (out_removed_b),
    .out_removed_c (out_removed_c),
    .out_length    (out_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // position of the first largest (or smallest) entry, counted from the head
  function automatic int first_extreme(input word_t q[$], input bit want_max);
    int best;
    best = 0;
    for (int i = 1; i < q.size(); i++) begin
      if (want_max ? (q[i] > q[best]) : (q[i] < q[best])) best = i;
    end
    return best;
  endfunction

  // applies one accepted word to the shadow queues and returns its result word
  function automatic result_t predict_queue_op(input logic [1:0] op,
                                               input word_t a, input word_t b,
                                               input word_t c);
    result_t r;
    int      pa;
    int      pb;
    int      pc;
    r = NO_RESULT;
    r.status = ST_OK;
    if (op == OP_ENQ) begin
      if (held_a.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_a.push_back(a);
        held_b.push_back(b);
        held_c.push_back(c);
      end
    end else if (held_a.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      if (op == OP_DEQ) begin
        pa = 0;
        pb = 0;
        pc = 0;
      end else begin
        pa = first_extreme(held_a, op == OP_DMAX);
        pb = first_extreme(held_b, op == OP_DMAX);
        pc = first_extreme(held_c, op == OP_DMAX);
      end
      r.removed_a = held_a[pa];
      r.removed_b = held_b[pb];
      r.removed_c = held_c[pc];
      held_a.delete(pa);
      held_b.delete(pb);
      held_c.delete(pc);
    end
    r.length = length_t'(held_a.size());
    return r;
  endfunction

  // mix of wide random values, tight clusters for ties, and the extremes
  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = word_t'($urandom_range(0, 6)) - 3;
      7: begin
        case ($urandom_range(0, 3))
          0:       v = VMAX;
          1:       v = VMIN;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      8:       v = VMIN + word_t'($urandom_range(0, 3));
      default: v = VMAX - word_t'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_op(input int enq_pct);
    if ($urandom_range(0, 99) < enq_pct) return OP_ENQ;
    case ($urandom_range(0, 2))
      0:       return OP_DEQ;
      1:       return OP_DMAX;
      default: return OP_DMIN;
    endcase
  endfunction

  // offers one word, idling first at the current rate, and returns on acceptance
  task automatic send_word(input logic [1:0] op, input word_t a, input word_t b,
                           input word_t c, input bit typed, input result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_op           <= op;
    in_value_a      <= a;
    in_value_b      <= b;
    in_value_c      <= c;
    word_typed      <= typed;
    word_typed_want <= want;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every outstanding result word has been collected
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // result checking first, then prediction of the word taken at the same edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t next;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_removed_a, out_removed_b, out_removed_c, out_length};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: st %0d a %0d b %0d c %0d len %0d",
                     got.status, got.removed_a, got.removed_b, got.removed_c,
                     got.length);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          case (want.status)
            ST_OK:    seen_ok++;
            ST_EMPTY: seen_empty++;
            default:  seen_full++;
          endcase
          if (got.status !== want.status || got.removed_a !== want.removed_a ||
              got.removed_b !== want.removed_b || got.removed_c !== want.removed_c ||
              got.length !== want.length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected st %0d a %0d b %0d c %0d len %0d, %s",
                       checked, want.status, want.removed_a, want.removed_b,
                       want.removed_c, want.length, "see next line");
            if (mismatches <= 10)
              $display("  got st %0d a %0d b %0d c %0d len %0d",
                       got.status, got.removed_a, got.removed_b, got.removed_c,
                       got.length);
          end
        end
      end
      if (in_valid && in_ready) begin
        next = predict_queue_op(in_op, in_value_a, in_value_b, in_value_c);
        if (held_a.size() > deepest) deepest = held_a.size();
        awaited_results.push_back(word_typed ? word_typed_want : next);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[triple_queue_extreme_delete_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_ENQ;
    in_value_a      = '0;
    in_value_b      = '0;
    in_value_c      = '0;
    word_typed      = 1'b0;
    word_typed_want = NO_RESULT;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening table, no idling
    foreach (opening_rows[r]) begin
      for (int k = 0; k < opening_rows[r].reps; k++)
        send_word(opening_rows[r].op, opening_rows[r].a, opening_rows[r].b,
                  opening_rows[r].c, opening_rows[r].typed, opening_rows[r].want);
    end
    wait_for_results();

    // random segments, each phase of idling twice, drained in between
    for (int s = 0; s < SEGMENTS; s++) begin
      send_idle_pct  = SEND_IDLE[s % 4];
      recv_stall_pct = RECV_STALL[s % 4];
      for (int k = 0; k < SEG_WORDS; k++)
        send_word(pick_op(ENQ_SHARE[s]), pick_value(), pick_value(), pick_value(),
                  1'b0, NO_RESULT);
      wait_for_results();
    end

    // quiet tail: nothing more may come out
    recv_stall_pct = 0;
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d result words: %0d ok, %0d empty, %0d full; deepest fill %0d",
             checked, seen_ok, seen_empty, seen_full, deepest);
    $display("mismatches %0d, still outstanding %0d", mismatches,
             awaited_results.size());
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[triple_queue_extreme_delete_unit] OK");
    end else begin
      $display("[triple_queue_extreme_delete_unit] ERROR");
    end
    $finish;
  end

endmodule
